### hdl/phong_point_light_shade_defines.svh
// Assertion macros used by the interface checker of the shading block.
`ifndef PHONG_POINT_LIGHT_SHADE_DEFINES_SVH
`define PHONG_POINT_LIGHT_SHADE_DEFINES_SVH

// Checked only while out of reset.
`define PLSH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLSH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/plsh_pkg.sv
// Shared types, constants and helpers of the Phong point-light shading block.
package plsh_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int SHINE_BITS_DEF  = 10;

  localparam logic [14:0] ONE14 = 15'd16384;
  localparam int NORM_TOP = 29;
  localparam int MAG_W    = 30;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int SQ_STEPS = 31;
  localparam int QUO_W    = 15;
  localparam int VEC_W    = 16;
  localparam int COL_W    = 10;
  localparam int OUT_W    = 12;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LIGHT_X       = 3'd0;
  localparam cfg_idx_t CFG_LIGHT_Y       = 3'd1;
  localparam cfg_idx_t CFG_LIGHT_Z       = 3'd2;
  localparam cfg_idx_t CFG_LIGHT_COLOR   = 3'd3;
  localparam cfg_idx_t CFG_AMBIENT_COLOR = 3'd4;

  typedef logic [2:0][VEC_W-1:0] vec_t;

  typedef struct packed {
    vec_t        nrm;
    vec_t        eye;
    logic [29:0] obj;
    logic [29:0] mat;
    logic        shadow;
  } side_t;

  // Channel k of a packed RGB word; red (k = 0) sits in the high bits.
  function automatic logic [COL_W-1:0] chan(input logic [29:0] c, input int k);
    chan = c[(2-k)*COL_W +: COL_W];
  endfunction

endpackage

### hdl/plsh_prep.sv
// Light vector difference, block normalization and sum of squares.
module plsh_prep import plsh_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][CW-1:0]    in_light,
  input  logic [2:0][CW-1:0]    in_point,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic [SUM_W-1:0]      out_sum,
  output logic [2:0][MAG_W-1:0] out_mag,
  output logic [2:0]            out_neg,
  output logic                  out_zero,
  output side_t                 out_side
);

  localparam int DW = CW + 1;
  localparam int PW = $clog2(DW);

  logic [5:0]              v_r;
  side_t [5:0]             side_r;
  logic [5:0][2:0]         neg_r;
  logic [2:0]              s0_neg_nxt;
  logic [2:0][DW-1:0]      s0_mag_r, s0_mag_nxt, s1_mag_r, s2_mag_r;
  logic [DW-1:0]           s1_max_r, s1_max_nxt;
  logic [PW-1:0]           s2_pos_r, s2_pos_nxt;
  logic [5:2]              zero_r;
  logic                    zero_nxt;
  logic [2:0][MAG_W-1:0]   s3_mag_r, s3_mag_nxt, s4_mag_r, s5_mag_r;
  logic [2:0][2*MAG_W-1:0] s4_sq_r, s4_sq_nxt;
  logic [SUM_W-1:0]        s5_sum_r, s5_sum_nxt;
  logic signed [DW-1:0]    d;
  logic [6:0]              pos7;
  logic [63:0]             t;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d = $signed({in_light[i][CW-1], in_light[i]}) - $signed({in_point[i][CW-1], in_point[i]});
      s0_neg_nxt[i] = d[DW-1];
      s0_mag_nxt[i] = d[DW-1] ? DW'(-d) : DW'(d);
    end

    s1_max_nxt = s0_mag_r[0];
    if (s0_mag_r[1] > s1_max_nxt) s1_max_nxt = s0_mag_r[1];
    if (s0_mag_r[2] > s1_max_nxt) s1_max_nxt = s0_mag_r[2];

    s2_pos_nxt = '0;
    for (int j = 0; j < DW; j++) begin
      if (s1_max_r[j]) s2_pos_nxt = PW'(j);
    end
    zero_nxt = (s1_max_r == '0);

    // One shift for all three so the largest lands with its top bit at bit 29.
    pos7 = 7'(s2_pos_r);
    for (int i = 0; i < 3; i++) begin
      t = 64'(s2_mag_r[i]);
      if (pos7 >= 7'(NORM_TOP)) t = t >> (pos7 - 7'(NORM_TOP));
      else                      t = t << (7'(NORM_TOP) - pos7);
      s3_mag_nxt[i] = t[MAG_W-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      s4_sq_nxt[i] = (2*MAG_W)'(s3_mag_r[i]) * (2*MAG_W)'(s3_mag_r[i]);
    end
    s5_sum_nxt = SUM_W'(s4_sq_r[0]) + SUM_W'(s4_sq_r[1]) + SUM_W'(s4_sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r   <= {side_r[4:0], in_side};
      neg_r    <= {neg_r[4:0], s0_neg_nxt};
      zero_r   <= {zero_r[4:2], zero_nxt};
      s0_mag_r <= s0_mag_nxt;
      s1_mag_r <= s0_mag_r;
      s1_max_r <= s1_max_nxt;
      s2_mag_r <= s1_mag_r;
      s2_pos_r <= s2_pos_nxt;
      s3_mag_r <= s3_mag_nxt;
      s4_mag_r <= s3_mag_r;
      s4_sq_r  <= s4_sq_nxt;
      s5_mag_r <= s4_mag_r;
      s5_sum_r <= s5_sum_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign out_sum   = s5_sum_r;
  assign out_mag   = s5_mag_r;
  assign out_neg   = neg_r[5];
  assign out_zero  = zero_r[5];
  assign out_side  = side_r[5];

endmodule

### hdl/plsh_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module plsh_sqrt import plsh_pkg::*; #(
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_x,
  input  logic [PW-1:0]     in_pay,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [PW-1:0]     out_pay
);

  localparam int XW = SUM_W + 1;

  logic [SQ_STEPS-1:0] v_r;
  logic [XW-1:0]       x_r   [SQ_STEPS];
  logic [XW-1:0]       r_r   [SQ_STEPS];
  logic [PW-1:0]       pay_r [SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SQ_STEPS-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [XW-1:0] BIT = XW'(1) << (2*(SQ_STEPS-1-k));
    logic [XW-1:0] xi, ri, t, x_nxt, r_nxt;
    logic [PW-1:0] pi;

    if (k == 0) begin : g_first
      assign xi = XW'(in_x);
      assign ri = '0;
      assign pi = in_pay;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign ri = r_r[k-1];
      assign pi = pay_r[k-1];
    end

    always_comb begin
      t = ri + BIT;
      if (xi >= t) begin
        x_nxt = xi - t;
        r_nxt = (ri >> 1) + BIT;
      end else begin
        x_nxt = xi;
        r_nxt = ri >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= x_nxt;
        r_r[k]   <= r_nxt;
        pay_r[k] <= pi;
      end
    end
  end

  assign out_valid = v_r[SQ_STEPS-1];
  assign out_root  = r_r[SQ_STEPS-1][ROOT_W-1:0];
  assign out_pay   = pay_r[SQ_STEPS-1];

endmodule

### hdl/plsh_div.sv
// Three lanes of pipelined restoring division giving the unit light vector.
module plsh_div import plsh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROOT_W-1:0]     in_len,
  input  logic [2:0][MAG_W-1:0] in_mag,
  input  logic [2:0]            in_neg,
  input  logic                  in_zero,
  input  side_t                 in_side,
  output logic                  out_valid,
  output vec_t                  out_l,
  output side_t                 out_side
);

  localparam int REM_W = ROOT_W + 1;

  typedef struct packed {
    logic [ROOT_W-1:0] len;
    logic [2:0]        neg;
    logic              zero;
    side_t             side;
  } div_car_t;

  logic [QUO_W:0]             v_r;
  logic [2:0][REM_W-1:0]      rem_r [QUO_W];
  logic [2:0][QUO_W-1:0]      q_r   [QUO_W];
  div_car_t                   car_r [QUO_W];
  vec_t                       l_r, l_nxt;
  side_t                      side_fin_r;
  div_car_t                   car_last;
  logic [QUO_W-1:0]           qc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QUO_W-1:0], in_valid};
    end
  end

  // Stage k settles quotient bit 14-k; the first stage works on the magnitude unshifted.
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [2:0][REM_W-1:0] ri, rem_nxt;
    logic [2:0][QUO_W-1:0] qi, q_nxt;
    div_car_t              ci;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          ri[i] = REM_W'(in_mag[i]);
        end
      end
      assign qi = '0;
      assign ci = '{len: in_len, neg: in_neg, zero: in_zero, side: in_side};
    end else begin : g_next
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          ri[i] = rem_r[k-1][i] << 1;
        end
      end
      assign qi = q_r[k-1];
      assign ci = car_r[k-1];
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if (ri[i] >= REM_W'(ci.len)) begin
          rem_nxt[i] = ri[i] - REM_W'(ci.len);
          q_nxt[i]   = {qi[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = ri[i];
          q_nxt[i]   = {qi[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        car_r[k] <= ci;
      end
    end
  end

  assign car_last = car_r[QUO_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc = (q_r[QUO_W-1][i] > ONE14) ? ONE14 : q_r[QUO_W-1][i];
      if (car_last.zero)        l_nxt[i] = '0;
      else if (car_last.neg[i]) l_nxt[i] = VEC_W'(-$signed({1'b0, qc}));
      else                      l_nxt[i] = VEC_W'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r        <= l_nxt;
      side_fin_r <= car_last.side;
    end
  end

  assign out_valid = v_r[QUO_W];
  assign out_l     = l_r;
  assign out_side  = side_fin_r;

endmodule

### hdl/plsh_spec.sv
// N.L, reflection vector, R.E and the clamped specular base.
module plsh_spec import plsh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  vec_t        in_l,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [31:0] out_nl,
  output logic        out_lit,
  output logic        out_spec,
  output logic [14:0] out_f,
  output side_t       out_side
);

  logic [6:0]        v_r;
  side_t [6:0]       side_r;
  logic [2:0][31:0]  p_r, p_nxt;
  vec_t              l0_r, l1_r, l2_r;
  logic [6:1][31:0]  nl_r;
  logic [31:0]       nl_nxt;
  logic [2:0][47:0]  m_r, m_nxt;
  logic [2:0][21:0]  r_r, r_nxt;
  logic [2:0][37:0]  q_r, q_nxt;
  logic [39:0]       re_r, re_nxt;
  logic              lit_r, spec_r, lit_nxt, spec_nxt, re_pos;
  logic [14:0]       f_r, f_nxt;
  logic signed [47:0] w;
  logic [47:0]       wa;
  logic [21:0]       sh;
  logic [25:0]       fr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_nxt[i] = 32'($signed(in_l[i])) * 32'($signed(in_side.nrm[i]));
    end
    nl_nxt = 32'($signed(p_r[0]) + $signed(p_r[1]) + $signed(p_r[2]));

    for (int i = 0; i < 3; i++) begin
      m_nxt[i] = 48'($signed(nl_r[1])) * 48'($signed(side_r[1].nrm[i]));
    end

    // 2(N.L)N scaled back to Q.14 with truncation toward zero, minus L.
    for (int i = 0; i < 3; i++) begin
      w  = $signed(m_r[i]) <<< 1;
      wa = w[47] ? 48'(-w) : 48'(w);
      sh = 22'(wa >> 28);
      r_nxt[i] = 22'((w[47] ? -$signed(sh) : $signed(sh)) - 22'($signed(l2_r[i])));
    end

    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = 38'($signed(r_r[i])) * 38'($signed(side_r[3].eye[i]));
    end
    re_nxt = 40'($signed(q_r[0])) + 40'($signed(q_r[1])) + 40'($signed(q_r[2]));

    lit_nxt  = !side_r[5].shadow && !nl_r[5][31];
    re_pos   = !re_r[39] && (re_r != '0);
    spec_nxt = lit_nxt && re_pos;
    fr       = re_r[39:14];
    if (!re_pos)                f_nxt = '0;
    else if (fr > 26'(ONE14))   f_nxt = ONE14;
    else                        f_nxt = fr[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= {side_r[5:0], in_side};
      p_r    <= p_nxt;
      l0_r   <= in_l;
      l1_r   <= l0_r;
      l2_r   <= l1_r;
      nl_r   <= {nl_r[5:1], nl_nxt};
      m_r    <= m_nxt;
      r_r    <= r_nxt;
      q_r    <= q_nxt;
      re_r   <= re_nxt;
      lit_r  <= lit_nxt;
      spec_r <= spec_nxt;
      f_r    <= f_nxt;
    end
  end

  assign out_valid = v_r[6];
  assign out_nl    = nl_r[6];
  assign out_lit   = lit_r;
  assign out_spec  = spec_r;
  assign out_f     = f_r;
  assign out_side  = side_r[6];

endmodule

### hdl/plsh_color.sv
// Specular power by square-and-multiply, then per-channel color sums with saturation.
module plsh_color import plsh_pkg::*; #(
  parameter int SB = SHINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [31:0]           in_nl,
  input  logic                  in_lit,
  input  logic                  in_spec,
  input  logic [14:0]           in_f,
  input  side_t                 in_side,
  input  logic [29:0]           light_color,
  input  logic [29:0]           ambient_color,
  output logic                  out_valid,
  output logic [2:0][OUT_W-1:0] out_rgb
);

  typedef struct packed {
    logic [31:0] nl;
    logic        lit;
    logic        spec;
    side_t       side;
  } pw_car_t;

  logic [SB+3:0]   v_r;
  logic [14:0]     acc_r  [SB];
  logic [14:0]     base_r [SB];
  pw_car_t         car_r  [SB];

  logic [2:0][19:0] eff_r, eff_nxt, lsks_r, lsks_nxt;
  logic [14:0]      fac0_r;
  pw_car_t          car0_r, car1_r, car2_r, car_pw;
  logic [2:0][13:0] amb_r, amb_nxt, amb2_r;
  logic [2:0][29:0] ek_r, ek_nxt;
  logic [2:0][12:0] sp_r, sp_nxt, sp2_r;
  logic [2:0][16:0] dif_r, dif_nxt;
  logic [2:0][OUT_W-1:0] rgb_r, rgb_nxt;
  logic [29:0]      amb_p;
  logic [34:0]      sp_p;
  logic [60:0]      dif_p;
  logic [17:0]      sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SB+2:0], in_valid};
    end
  end

  // Stage k applies shininess bit k.
  for (genvar k = 0; k < SB; k++) begin : g_pow
    logic [14:0] ai, bi, acc_nxt, base_nxt;
    logic [29:0] pa, pb;
    pw_car_t     ci;

    if (k == 0) begin : g_first
      assign ai = ONE14;
      assign bi = in_f;
      assign ci = '{nl: in_nl, lit: in_lit, spec: in_spec, side: in_side};
    end else begin : g_next
      assign ai = acc_r[k-1];
      assign bi = base_r[k-1];
      assign ci = car_r[k-1];
    end

    always_comb begin
      pa       = 30'(ai) * 30'(bi);
      pb       = 30'(bi) * 30'(bi);
      acc_nxt  = ci.side.mat[k] ? pa[28:14] : ai;
      base_nxt = pb[28:14];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[k]  <= acc_nxt;
        base_r[k] <= base_nxt;
        car_r[k]  <= ci;
      end
    end
  end

  assign car_pw = car_r[SB-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      eff_nxt[k]  = 20'(chan(car_pw.side.obj, k)) * 20'(chan(light_color, k));
      lsks_nxt[k] = 20'(chan(light_color, k)) * 20'(car_pw.side.mat[19:10]);
    end

    for (int k = 0; k < 3; k++) begin
      amb_p      = 30'(eff_r[k]) * 30'(chan(ambient_color, k));
      amb_nxt[k] = amb_p[29:16];
      ek_nxt[k]  = 30'(eff_r[k]) * 30'(car0_r.side.mat[29:20]);
      sp_p       = 35'(lsks_r[k]) * 35'(fac0_r);
      sp_nxt[k]  = sp_p[34:22];
    end

    for (int k = 0; k < 3; k++) begin
      dif_p      = 61'(ek_r[k]) * 61'(car1_r.nl[30:0]);
      dif_nxt[k] = dif_p[60:44];
    end

    for (int k = 0; k < 3; k++) begin
      sum = 18'(amb2_r[k]) + (car2_r.lit ? 18'(dif_r[k]) : 18'd0)
          + (car2_r.spec ? 18'(sp2_r[k]) : 18'd0);
      rgb_nxt[k] = (sum > 18'd4095) ? 12'd4095 : sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eff_r  <= eff_nxt;
      lsks_r <= lsks_nxt;
      fac0_r <= acc_r[SB-1];
      car0_r <= car_pw;
      amb_r  <= amb_nxt;
      ek_r   <= ek_nxt;
      sp_r   <= sp_nxt;
      car1_r <= car0_r;
      dif_r  <= dif_nxt;
      amb2_r <= amb_r;
      sp2_r  <= sp_r;
      car2_r <= car1_r;
      rgb_r  <= rgb_nxt;
    end
  end

  assign out_valid = v_r[SB+3];
  assign out_rgb   = rgb_r;

endmodule

### hdl/phong_point_light_shade.sv
// Phong point-light shading: takes one surface point per cycle while in_tready is high and
// returns one RGB result per point, in order. A result passes through the pipeline stages and
// then is registered in the output buffer before it shows on out_tvalid. The pipeline depth is
// set mostly by the 31-stage square root and the divider that normalize the light vector, and by
// one stage per shininess bit in the specular power. A two-entry output buffer lets the pipeline
// keep moving while a result waits; when both entries are full the whole pipeline holds and
// in_tready drops. Configuration is taken at once (cfg_ready is always high) and must be written
// only while no item is in flight.
module phong_point_light_shade import plsh_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int SHINE_BITS  = SHINE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z, eye_x, eye_y, eye_z,
  // object_color, material, then zero fill
  input  logic [255:0] in_tdata,
  // shadow flag
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // red, green, blue, then zero fill
  output logic [39:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  cfg_idx_t     cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  zero;
    side_t                 side;
  } sq_pay_t;

  logic [2:0][31:0] light_r;
  logic [29:0]      light_color_r, ambient_color_r;

  logic             en;
  side_t            in_side;
  logic [2:0][CW-1:0] light_c, point_c;

  logic                  pr_valid;
  logic [SUM_W-1:0]      pr_sum;
  logic [2:0][MAG_W-1:0] pr_mag;
  logic [2:0]            pr_neg;
  logic                  pr_zero;
  side_t                 pr_side;
  sq_pay_t               sq_in_pay, sq_out_pay;
  logic                  sq_valid;
  logic [ROOT_W-1:0]     sq_root;
  logic                  dv_valid;
  vec_t                  dv_l;
  side_t                 dv_side;
  logic                  sp_valid, sp_lit, sp_spec;
  logic [31:0]           sp_nl;
  logic [14:0]           sp_f;
  side_t                 sp_side;
  logic                  co_valid;
  logic [2:0][OUT_W-1:0] co_rgb;

  logic [2:0][OUT_W-1:0] buf_r [2];
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r         <= '0;
      light_color_r   <= '0;
      ambient_color_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIGHT_X:       light_r[0]      <= cfg_data;
        CFG_LIGHT_Y:       light_r[1]      <= cfg_data;
        CFG_LIGHT_Z:       light_r[2]      <= cfg_data;
        CFG_LIGHT_COLOR:   light_color_r   <= cfg_data[29:0];
        CFG_AMBIENT_COLOR: ambient_color_r <= cfg_data[29:0];
        default: ;
      endcase
    end
  end

  assign in_side = '{
    nrm:    {in_tdata[143:128], in_tdata[127:112], in_tdata[111:96]},
    eye:    {in_tdata[191:176], in_tdata[175:160], in_tdata[159:144]},
    obj:    in_tdata[221:192],
    mat:    in_tdata[251:222],
    shadow: in_tuser[0]
  };

  // Narrow coordinates are sign-extended from their low bits; wide ones carry 32-bit values
  // as non-negative.
  for (genvar i = 0; i < 3; i++) begin : g_coord
    if (CW <= 32) begin : g_narrow
      assign point_c[i] = in_tdata[32*i +: CW];
      assign light_c[i] = light_r[i][CW-1:0];
    end else begin : g_wide
      assign point_c[i] = {{(CW-32){1'b0}}, in_tdata[32*i +: 32]};
      assign light_c[i] = {{(CW-32){1'b0}}, light_r[i]};
    end
  end

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  plsh_prep #(.CW(CW)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_light (light_c),
    .in_point (point_c),
    .in_side  (in_side),
    .out_valid(pr_valid),
    .out_sum  (pr_sum),
    .out_mag  (pr_mag),
    .out_neg  (pr_neg),
    .out_zero (pr_zero),
    .out_side (pr_side)
  );

  assign sq_in_pay = '{mag: pr_mag, neg: pr_neg, zero: pr_zero, side: pr_side};

  plsh_sqrt #(.PW($bits(sq_pay_t))) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (pr_valid),
    .in_x     (pr_sum),
    .in_pay   (sq_in_pay),
    .out_valid(sq_valid),
    .out_root (sq_root),
    .out_pay  (sq_out_pay)
  );

  plsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (sq_valid),
    .in_len   (sq_root),
    .in_mag   (sq_out_pay.mag),
    .in_neg   (sq_out_pay.neg),
    .in_zero  (sq_out_pay.zero),
    .in_side  (sq_out_pay.side),
    .out_valid(dv_valid),
    .out_l    (dv_l),
    .out_side (dv_side)
  );

  plsh_spec u_spec (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (dv_valid),
    .in_l     (dv_l),
    .in_side  (dv_side),
    .out_valid(sp_valid),
    .out_nl   (sp_nl),
    .out_lit  (sp_lit),
    .out_spec (sp_spec),
    .out_f    (sp_f),
    .out_side (sp_side)
  );

  plsh_color #(.SB(SHINE_BITS)) u_color (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (sp_valid),
    .in_nl        (sp_nl),
    .in_lit       (sp_lit),
    .in_spec      (sp_spec),
    .in_f         (sp_f),
    .in_side      (sp_side),
    .light_color  (light_color_r),
    .ambient_color(ambient_color_r),
    .out_valid    (co_valid),
    .out_rgb      (co_rgb)
  );

  assign push = en && co_valid;
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= co_rgb;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {4'b0, buf_r[rd_ptr_r][2], buf_r[rd_ptr_r][1], buf_r[rd_ptr_r][0]};

endmodule

### hdl/plsh_chk.sv
// Port-level checker for the shading block and its bind.
`include "phong_point_light_shade_defines.svh"

module plsh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  `PLSH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `PLSH_ASSERT(a_full_has_out, !in_tready |-> out_tvalid, "input stalled with no result waiting")
  `PLSH_ASSERT(a_full_stays, !in_tready && !out_tready |=> !in_tready, "full buffer drained without a transaction")
  `PLSH_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result shown right after reset")

endmodule

bind phong_point_light_shade plsh_chk u_chk (.*);
